/* hw/rtl/pidl_pkg.sv */
// pidl_pkg: request and status codes and the per-cell control structs of the
// positional insert/delete list. No dependencies.
`default_nettype none

package pidl_pkg;

   localparam int DATA_W  = 32;
   localparam int POS_W   = 7;
   localparam int COUNT_W = 7;

   typedef logic [1:0] req_code_type;
   localparam req_code_type REQ_INSERT = 2'd0;
   localparam req_code_type REQ_DELETE = 2'd1;
   localparam req_code_type REQ_READ   = 2'd2;

   typedef logic [1:0] status_type;
   localparam status_type ST_OK    = 2'd0;
   localparam status_type ST_RANGE = 2'd1;
   localparam status_type ST_FULL  = 2'd2;
   localparam status_type ST_EMPTY = 2'd3;

   // command broadcast to every cell
   typedef struct packed {
      logic shift_up;
      logic shift_down;
      logic rd_load;
      logic rd_shift;
   } cell_cmd_type;

   // where a cell sits relative to the requested position
   typedef struct packed {
      logic at_pos;
      logic above_pos;
   } cell_sel_type;

endpackage

`default_nettype wire

/* hw/rtl/pidl_if.sv */
// pidl_req_if and pidl_rsp_if: valid/ready channels of the list unit.
// Depends on pidl_pkg for field widths.
`default_nettype none

interface pidl_req_if;
   logic                               valid;
   logic                               ready;
   logic [1:0]                         req_type;
   logic [pidl_pkg::POS_W-1:0]         position;
   logic signed [pidl_pkg::DATA_W-1:0] value;

   modport source (output valid, output req_type, output position, output value,
                   input ready);
   modport sink   (input valid, input req_type, input position, input value,
                   output ready);
endinterface

interface pidl_rsp_if;
   logic                               valid;
   logic                               ready;
   logic [1:0]                         status;
   logic signed [pidl_pkg::DATA_W-1:0] read_value;
   logic [pidl_pkg::COUNT_W-1:0]       count;

   modport source (output valid, output status, output read_value, output count,
                   input ready);
   modport sink   (input valid, input status, input read_value, input count,
                   output ready);
endinterface

`default_nettype wire

/* hw/rtl/pidl_cell.sv */
// pidl_cell: one list entry plus one stage of the read return chain.
// Depends on pidl_pkg for the command and select structs.
`default_nettype none

module pidl_cell (
   input  wire logic                               clock,
   input  wire pidl_pkg::cell_cmd_type             cmd,
   input  wire pidl_pkg::cell_sel_type             sel,
   input  wire logic signed [pidl_pkg::DATA_W-1:0] value,
   input  wire logic signed [pidl_pkg::DATA_W-1:0] left_data,
   input  wire logic signed [pidl_pkg::DATA_W-1:0] right_data,
   input  wire logic signed [pidl_pkg::DATA_W-1:0] right_rd,
   output logic signed [pidl_pkg::DATA_W-1:0]      data,
   output logic signed [pidl_pkg::DATA_W-1:0]      rd
);

   logic signed [pidl_pkg::DATA_W-1:0] data_ff, data_in;
   logic signed [pidl_pkg::DATA_W-1:0] rd_ff, rd_in;

   always_comb begin
      data_in = data_ff;
      if (cmd.shift_up && sel.at_pos) begin
         data_in = value;
      end else if (cmd.shift_up && sel.above_pos) begin
         data_in = left_data;
      end else if (cmd.shift_down && (sel.at_pos || sel.above_pos)) begin
         data_in = right_data;
      end
   end

   // only the addressed cell loads its word, then the chain drains toward cell 0
   always_comb begin
      rd_in = rd_ff;
      if (cmd.rd_load) begin
         rd_in = sel.at_pos ? data_ff : '0;
      end else if (cmd.rd_shift) begin
         rd_in = right_rd;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
      rd_ff   <= rd_in;
   end

   assign data = data_ff;
   assign rd   = rd_ff;

endmodule

`default_nettype wire

/* hw/rtl/positional_insert_delete_list_unit.sv */
// positional_insert_delete_list_unit: ordered list of signed 32-bit words.
// Depends on pidl_pkg, pidl_req_if, pidl_rsp_if and pidl_cell.
//
// Usage:
//   req_chan carries one request beat (insert, delete or read at a position);
//   rsp_chan returns one beat per request with status, read value and count.
//   Both are valid/ready; a beat moves when valid and ready are high at a
//   rising clock edge.
// Request handling:
//   insert, delete and every rejected request answer in the cycle after the
//   request beat; with rsp_chan.ready high, the next request can go then too.
//   A successful read at position p loads its word into the return chain:
//   it walks down the row of cells one cell per cycle to cell 0, then into
//   the response register. All entries shift together, one cell per entry.
// Reset:
//   synchronous, active high; the list is empty and no response is pending.
//   Entry contents are not cleared.
// Back-pressure:
//   the response waits in an output register while rsp_chan.ready is low;
//   a new request is taken only once that register is free or being drained.
`default_nettype none

module positional_insert_delete_list_unit #(
   parameter int CAPACITY = 64
) (
   input  wire logic   clock,
   input  wire logic   reset,
   pidl_req_if.sink    req_chan,
   pidl_rsp_if.source  rsp_chan
);

   localparam int CW = $clog2(CAPACITY + 1);
   localparam int PW = (CW > pidl_pkg::POS_W) ? CW : pidl_pkg::POS_W;

   typedef enum logic [1:0] {
      S_IDLE = 2'b01,
      S_SEEK = 2'b10
   } state_type;

   state_type state_ff, state_in;

   logic [CW-1:0] count_ff, count_in;
   logic [PW-1:0] seek_ff, seek_in;

   logic                               rsp_valid_ff, rsp_valid_in;
   pidl_pkg::status_type               rsp_status_ff, rsp_status_in;
   logic signed [pidl_pkg::DATA_W-1:0] rsp_value_ff, rsp_value_in;
   logic [pidl_pkg::COUNT_W-1:0]       rsp_count_ff, rsp_count_in;

   logic                 accept;
   logic [PW-1:0]        pos_ext;
   logic [PW-1:0]        count_ext;
   pidl_pkg::status_type req_status;
   logic                 req_ok;
   logic                 is_insert, is_delete, is_read;

   pidl_pkg::cell_cmd_type             cmd;
   pidl_pkg::cell_sel_type             sel   [CAPACITY];
   logic signed [pidl_pkg::DATA_W-1:0] data_w[CAPACITY];
   logic signed [pidl_pkg::DATA_W-1:0] rd_w  [CAPACITY];

   assign req_chan.ready = (state_ff == S_IDLE) && (!rsp_valid_ff || rsp_chan.ready);
   assign accept         = req_chan.valid && req_chan.ready;

   assign pos_ext   = PW'(req_chan.position);
   assign count_ext = PW'(count_ff);

   assign is_insert = (req_chan.req_type == pidl_pkg::REQ_INSERT);
   assign is_delete = (req_chan.req_type == pidl_pkg::REQ_DELETE);
   assign is_read   = (req_chan.req_type == pidl_pkg::REQ_READ);

   always_comb begin
      req_status = pidl_pkg::ST_RANGE;
      case (req_chan.req_type)
         pidl_pkg::REQ_INSERT: begin
            if (count_ff == CW'(CAPACITY)) begin
               req_status = pidl_pkg::ST_FULL;
            end else if (pos_ext > count_ext) begin
               req_status = pidl_pkg::ST_RANGE;
            end else begin
               req_status = pidl_pkg::ST_OK;
            end
         end
         pidl_pkg::REQ_DELETE, pidl_pkg::REQ_READ: begin
            if (count_ff == '0) begin
               req_status = pidl_pkg::ST_EMPTY;
            end else if (pos_ext >= count_ext) begin
               req_status = pidl_pkg::ST_RANGE;
            end else begin
               req_status = pidl_pkg::ST_OK;
            end
         end
         default: begin
            req_status = pidl_pkg::ST_RANGE;
         end
      endcase
   end

   assign req_ok = (req_status == pidl_pkg::ST_OK);

   assign cmd.shift_up   = accept && req_ok && is_insert;
   assign cmd.shift_down = accept && req_ok && is_delete;
   assign cmd.rd_load    = accept && req_ok && is_read;
   assign cmd.rd_shift   = (state_ff == S_SEEK) && (seek_ff != '0);

   // row of cells, each seeing its neighbors
   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic signed [pidl_pkg::DATA_W-1:0] left_data;
      logic signed [pidl_pkg::DATA_W-1:0] right_data;
      logic signed [pidl_pkg::DATA_W-1:0] right_rd;

      assign sel[i].at_pos    = (pos_ext == PW'(i));
      assign sel[i].above_pos = (pos_ext < PW'(i));

      if (i == 0) begin : g_first
         assign left_data = '0;
      end else begin : g_mid_l
         assign left_data = data_w[i-1];
      end

      if (i == CAPACITY - 1) begin : g_last
         assign right_data = '0;
         assign right_rd   = '0;
      end else begin : g_mid_r
         assign right_data = data_w[i+1];
         assign right_rd   = rd_w[i+1];
      end

      pidl_cell u_cell (
         .clock      (clock),
         .cmd        (cmd),
         .sel        (sel[i]),
         .value      (req_chan.value),
         .left_data  (left_data),
         .right_data (right_data),
         .right_rd   (right_rd),
         .data       (data_w[i]),
         .rd         (rd_w[i])
      );
   end

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      seek_in       = seek_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_status_in = rsp_status_ff;
      rsp_value_in  = rsp_value_ff;
      rsp_count_in  = rsp_count_ff;

      if (rsp_valid_ff && rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               if (cmd.shift_up) begin
                  count_in = count_ff + 1'b1;
               end else if (cmd.shift_down) begin
                  count_in = count_ff - 1'b1;
               end
               rsp_status_in = req_status;
               rsp_value_in  = '0;
               rsp_count_in  = pidl_pkg::COUNT_W'(count_in);
               if (cmd.rd_load) begin
                  seek_in  = pos_ext;
                  state_in = S_SEEK;
               end else begin
                  rsp_valid_in = 1'b1;
               end
            end
         end
         S_SEEK: begin
            if (seek_ff == '0) begin
               rsp_value_in = rd_w[0];
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end else begin
               seek_in = seek_ff - 1'b1;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      seek_ff       <= seek_in;
      rsp_status_ff <= rsp_status_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_count_ff  <= rsp_count_in;
   end

   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.status     = rsp_status_ff;
   assign rsp_chan.read_value = rsp_value_ff;
   assign rsp_chan.count      = rsp_count_ff;

   // list never holds more than its capacity
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(CAPACITY))
      else $error("entry count above capacity");

   // a good insert grows the list by exactly one
   a_insert_grow: assert property (@(posedge clock) disable iff (reset)
      cmd.shift_up |=> count_ff == $past(count_ff) + 1'b1)
      else $error("insert did not bump count");

   // a good read walks the return chain, blocking new requests meanwhile
   a_read_seek: assert property (@(posedge clock) disable iff (reset)
      cmd.rd_load |=> (state_ff == S_SEEK) && !rsp_valid_ff)
      else $error("read did not enter seek");

   a_seek_block: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SEEK) |-> !req_chan.ready)
      else $error("request taken during read seek");

endmodule

`default_nettype wire

/* tb/sv/positional_insert_delete_list_checker.sv */
// positional_insert_delete_list_checker: watches the request and response channels of the
// list unit, keeps its own copy of the list and compares every response beat.
// Depends on pidl_pkg for field widths and the request and status codes.

module positional_insert_delete_list_checker
   import pidl_pkg::*;
#(
   parameter int CAPACITY = 64
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   input  logic                     req_ready,
   input  logic [1:0]               req_type,
   input  logic [POS_W-1:0]         req_position,
   input  logic signed [DATA_W-1:0] req_value,
   input  logic                     rsp_valid,
   input  logic                     rsp_ready,
   input  logic [1:0]               rsp_status,
   input  logic signed [DATA_W-1:0] rsp_read_value,
   input  logic [COUNT_W-1:0]       rsp_count,
   output int                       error_count,
   output int                       answers_pending
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      status_type               status;
      logic signed [DATA_W-1:0] read_value;
      logic [COUNT_W-1:0]       count;
   } list_answer_type;

   logic signed [DATA_W-1:0] list_words [CAPACITY];
   int                       list_len;
   list_answer_type          answers_due [$];
   list_answer_type          due_answer;
   int                       mismatches;

   initial begin
      list_len        = 0;
      mismatches      = 0;
      error_count     = 0;
      answers_pending = 0;
      foreach (list_words[i]) list_words[i] = '0;
   end

   // applies one request to the local list and returns the answer it should get
   function automatic list_answer_type apply_list_request(input logic [1:0] kind,
                                                          input logic [POS_W-1:0] pos,
                                                          input logic signed [DATA_W-1:0] val);
      list_answer_type answer;
      answer.status     = ST_OK;
      answer.read_value = '0;
      if (kind == REQ_INSERT) begin
         if (list_len >= CAPACITY) begin
            answer.status = ST_FULL;
         end else if (int'(pos) > list_len) begin
            answer.status = ST_RANGE;
         end else begin
            for (int i = list_len; i > int'(pos); i--) list_words[i] = list_words[i-1];
            list_words[pos] = val;
            list_len++;
         end
      end else if (kind == REQ_DELETE || kind == REQ_READ) begin
         if (list_len == 0) begin
            answer.status = ST_EMPTY;
         end else if (int'(pos) >= list_len) begin
            answer.status = ST_RANGE;
         end else if (kind == REQ_READ) begin
            answer.read_value = list_words[pos];
         end else begin
            for (int i = int'(pos); i + 1 < list_len; i++) list_words[i] = list_words[i+1];
            list_len--;
         end
      end else begin
         answer.status = ST_RANGE;
      end
      answer.count = COUNT_W'(list_len);
      return answer;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         list_len = 0;
         answers_due.delete();
      end else begin
         // the response side goes first: a beat leaving now belongs to an older request
         if (rsp_valid && rsp_ready) begin
            if (answers_due.size() == 0) begin
               $error("response beat with no request waiting: status %0d count %0d",
                      rsp_status, rsp_count);
               mismatches++;
            end else begin
               due_answer = answers_due.pop_front();
               if (rsp_status !== due_answer.status) begin
                  $error("status: expected %0d, actual %0d", due_answer.status, rsp_status);
                  mismatches++;
               end
               if (rsp_read_value !== due_answer.read_value) begin
                  $error("read_value: expected %0d, actual %0d",
                         due_answer.read_value, rsp_read_value);
                  mismatches++;
               end
               if (rsp_count !== due_answer.count) begin
                  $error("count: expected %0d, actual %0d", due_answer.count, rsp_count);
                  mismatches++;
               end
            end
         end
         if (req_valid && req_ready)
            answers_due.push_back(apply_list_request(req_type, req_position, req_value));
      end
      answers_pending <= answers_due.size();
      error_count     <= mismatches;
   end

endmodule

/* tb/sv/positional_insert_delete_list_unit_test.sv */
// positional_insert_delete_list_unit_test: drives requests into the list unit with random
// gaps and response stalls; the checker module predicts and compares.
// Depends on pidl_pkg, pidl_req_if, pidl_rsp_if and the checker module.

module positional_insert_delete_list_unit_test;
   timeunit 1ns;
   timeprecision 1ps;
   import pidl_pkg::*;

   localparam int           LIST_DEPTH   = 64;
   localparam int           HOLD_CYCLES  = 300;
   localparam int           TAIL_CYCLES  = 80;
   localparam req_code_type REQ_UNUSED   = 2'd3;
   localparam logic [31:0]  WORD_MAX     = 32'h7fff_ffff;
   localparam logic [31:0]  WORD_MIN     = 32'h8000_0000;
   localparam logic [31:0]  WORD_ONES    = 32'hffff_ffff;

   logic clock;
   logic reset;
   int   errors_seen;
   int   answers_pending;
   int   list_fill;
   bit   gaps_on;
   bit   stalls_on;
   bit   hold_request;

   pidl_req_if req_bus ();
   pidl_rsp_if rsp_bus ();

   positional_insert_delete_list_unit #(
      .CAPACITY (LIST_DEPTH)
   ) i_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus)
   );

   positional_insert_delete_list_checker #(
      .CAPACITY (LIST_DEPTH)
   ) i_checker (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_bus.valid),
      .req_ready       (req_bus.ready),
      .req_type        (req_bus.req_type),
      .req_position    (req_bus.position),
      .req_value       (req_bus.value),
      .rsp_valid       (rsp_bus.valid),
      .rsp_ready       (rsp_bus.ready),
      .rsp_status      (rsp_bus.status),
      .rsp_read_value  (rsp_bus.read_value),
      .rsp_count       (rsp_bus.count),
      .error_count     (errors_seen),
      .answers_pending (answers_pending)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   initial begin
      #4_000_000;
      $display("[positional_insert_delete_list_unit] ERROR");
      $finish;
   end

   // response side: random stall bursts, plus one long hold-off on request
   initial begin
      rsp_bus.ready <= 1'b0;
      forever begin
         if (hold_request) begin
            rsp_bus.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_request = 1'b0;
         end else if (stalls_on && $urandom_range(0, 2) == 0) begin
            rsp_bus.ready <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge clock);
         end else begin
            rsp_bus.ready <= 1'b1;
            repeat ($urandom_range(1, 20)) @(posedge clock);
         end
      end
   end

   function automatic logic [31:0] pick_value();
      case ($urandom_range(0, 11))
         0:       return WORD_MAX;
         1:       return WORD_MIN;
         2:       return '0;
         3:       return WORD_ONES;
         default: return $urandom;
      endcase
   endfunction

   // offers one beat and returns at the edge that takes it; valid stays high
   task automatic send_item(input req_code_type kind, input logic [6:0] pos,
                            input logic [31:0] val);
      req_bus.valid    <= 1'b1;
      req_bus.req_type <= kind;
      req_bus.position <= pos;
      req_bus.value    <= val;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      // occupancy only, to steer positions toward legal ones
      if (kind == REQ_INSERT && list_fill < LIST_DEPTH && int'(pos) <= list_fill)
         list_fill++;
      else if (kind == REQ_DELETE && int'(pos) < list_fill)
         list_fill--;
   endtask

   task automatic idle_gap(input int cycles);
      req_bus.valid <= 1'b0;
      repeat (cycles) @(posedge clock);
   endtask

   task automatic wait_drained();
      req_bus.valid <= 1'b0;
      do @(posedge clock); while (answers_pending != 0);
   endtask

   task automatic random_request(input int grow_pct, input int shrink_pct);
      int           roll;
      req_code_type kind;
      logic [6:0]   pos;
      roll = $urandom_range(0, 99);
      if (roll < 6) begin
         // noise: unused code or a position anywhere in the field
         kind = $urandom_range(0, 1) ? REQ_UNUSED : req_code_type'($urandom_range(0, 2));
         pos  = 7'($urandom_range(0, 127));
      end else if (roll < 6 + grow_pct) begin
         kind = REQ_INSERT;
         pos  = 7'($urandom_range(0, list_fill));
      end else begin
         kind = (roll < 6 + grow_pct + shrink_pct) ? REQ_DELETE : REQ_READ;
         pos  = (list_fill == 0) ? 7'd0 : 7'($urandom_range(0, list_fill - 1));
      end
      send_item(kind, pos, pick_value());
      if (gaps_on && $urandom_range(0, 3) == 0) idle_gap($urandom_range(1, 15));
   endtask

   initial begin
      reset            <= 1'b1;
      req_bus.valid    <= 1'b0;
      req_bus.req_type <= REQ_INSERT;
      req_bus.position <= '0;
      req_bus.value    <= '0;
      list_fill    = 0;
      gaps_on      = 1'b1;
      stalls_on    = 1'b1;
      hold_request = 1'b0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // empty list, unused code and positions past the count, plus inserts, reads and deletes
      send_item(REQ_READ, 7'd0, WORD_ONES);
      send_item(REQ_DELETE, 7'd0, '0);
      send_item(REQ_UNUSED, 7'd127, WORD_ONES);
      send_item(REQ_INSERT, 7'd1, WORD_MAX);
      send_item(REQ_INSERT, 7'd0, WORD_MAX);
      send_item(REQ_INSERT, 7'd0, WORD_MIN);
      idle_gap(3);
      send_item(REQ_INSERT, 7'd2, WORD_ONES);
      send_item(REQ_INSERT, 7'd1, '0);
      send_item(REQ_READ, 7'd0, '0);
      send_item(REQ_READ, 7'd1, '0);
      send_item(REQ_READ, 7'd2, '0);
      send_item(REQ_READ, 7'd3, '0);
      send_item(REQ_READ, 7'd4, '0);
      send_item(REQ_DELETE, 7'd4, '0);
      send_item(REQ_READ, 7'd127, '0);
      send_item(REQ_INSERT, 7'd127, WORD_MAX);
      send_item(REQ_DELETE, 7'd0, '0);
      send_item(REQ_DELETE, 7'd2, '0);
      send_item(REQ_UNUSED, 7'd0, $urandom);
      send_item(REQ_READ, 7'd0, '0);
      send_item(REQ_READ, 7'd1, '0);
      send_item(REQ_INSERT, 7'd2, $urandom);

      // fill to capacity, then the full cases and the top entry
      while (list_fill < LIST_DEPTH) begin
         send_item(REQ_INSERT, 7'($urandom_range(0, list_fill)), pick_value());
         if ($urandom_range(0, 4) == 0) idle_gap($urandom_range(1, 15));
      end
      send_item(REQ_INSERT, 7'd0, $urandom);
      send_item(REQ_INSERT, 7'd127, $urandom);
      send_item(REQ_INSERT, 7'(LIST_DEPTH), $urandom);
      send_item(REQ_READ, 7'(LIST_DEPTH - 1), '0);
      send_item(REQ_READ, 7'(LIST_DEPTH), '0);
      send_item(REQ_DELETE, 7'(LIST_DEPTH), '0);
      send_item(REQ_DELETE, 7'(LIST_DEPTH - 1), '0);
      send_item(REQ_INSERT, 7'(LIST_DEPTH - 1), WORD_MIN);
      send_item(REQ_READ, 7'(LIST_DEPTH - 1), '0);

      repeat (40) random_request(30, 30);

      // long response hold-off while requests keep coming, so the unit stalls its input
      hold_request = 1'b1;
      repeat (20) random_request(30, 30);

      // sender waits for every outstanding answer before going on
      wait_drained();

      repeat (150) random_request(15, 55);
      repeat (150) random_request(60, 15);

      // last stretch without any idling
      gaps_on   = 1'b0;
      stalls_on = 1'b0;
      repeat (150) random_request(35, 30);

      wait_drained();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (errors_seen == 0)
         $display("[positional_insert_delete_list_unit] OK");
      else
         $display("[positional_insert_delete_list_unit] ERROR");
      $finish;
   end

endmodule
